>>> design/wbor_pkg.sv
// ----------------------------------------------------------------------------
// wbor_pkg: shared constants for the wall-bump odometry recalibration core
// Field widths, configuration indexes, distance limits and the fixed
// coordinates used for goals and odometry corrections.
// ----------------------------------------------------------------------------
`default_nettype none

package wbor_pkg;

  // field widths
  localparam int unsigned POS_W    = 13;
  localparam int unsigned X_W      = 12;
  localparam int unsigned Y_W      = 11;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 56;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_CORNER  = 2'd2,
    CFG_IS_BLUE = 2'd3
  } cfg_index_t;

  // configuration reset values
  localparam logic [X_W-1:0] START_X_RST = 12'd700;
  localparam logic [Y_W-1:0] START_Y_RST = 11'd1360;

  // stall detection
  localparam int unsigned STALL_TICKS = 100;

  // arrival window: squared distance below 40 mm
  localparam int unsigned ARRIVE_RADIUS = 40;
  localparam int unsigned ARRIVE_SQ     = 1600;
  // stillness window: squared distance below 5 mm
  localparam int unsigned STILL_RADIUS  = 5;
  localparam int unsigned STILL_SQ      = 25;

  // wall thresholds
  localparam logic signed [POS_W-1:0] X_LOW_LIMIT  = 13'sd150;
  localparam logic signed [POS_W-1:0] X_HIGH_LIMIT = 13'sd2850;
  localparam logic signed [POS_W-1:0] Y_LOW_LIMIT  = 13'sd150;
  localparam logic signed [POS_W-1:0] Y_HIGH_LIMIT = 13'sd1850;

  // wall goals and corrected odometry values
  localparam logic [X_W-1:0] X_WALL_FAR  = 12'd3000;
  localparam logic [Y_W-1:0] Y_WALL_FAR  = 11'd2000;
  localparam logic [X_W-1:0] FIX_X_NEAR  = 12'd95;
  localparam logic [X_W-1:0] FIX_X_FAR   = 12'd2905;
  localparam logic [Y_W-1:0] FIX_Y_NEAR  = 11'd95;
  localparam logic [Y_W-1:0] FIX_Y_FAR   = 11'd1905;

  // one result item
  typedef struct packed {
    logic [PHASE_W-1:0] phase_out;
    logic [Y_W-1:0]     fix_y_value;
    logic               fix_y_valid;
    logic [X_W-1:0]     fix_x_value;
    logic               fix_x_valid;
    logic               recalibrating;
    logic               goal_wall_mode;
    logic [Y_W-1:0]     goal_y;
    logic [X_W-1:0]     goal_x;
    logic               goal_valid;
  } result_t;

endpackage

`default_nettype wire

>>> design/wall_bump_odometry_recalibration_core.sv
// A request accepted into the input register has its result registered in
// the result register once that register is free; m_tvalid rises with it.
// Throughput: one request per cycle while m_tready keeps the result
// register free; the phase, candidate and counter update is combinational
// logic between the input and the result register.
// Reset (rst, synchronous): phase 0, counters, candidate and flag cleared,
// configuration back to start 700/1360, corner 0, team 0; both stages empty.
// ----------------------------------------------------------------------------
// wall_bump_odometry_recalibration_core: wall-bump homing sequencer
// Steers the robot to the start point, into the X wall, back, into the Y
// wall and back, overwriting odometry X and Y when each wall stalls the robot.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_bump_odometry_recalibration_core #(
  parameter int unsigned STALL_TICKS = wbor_pkg::STALL_TICKS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [wbor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wbor_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream: [12:0] pos_x, [25:13] pos_y, [31:26] zero
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [wbor_pkg::IN_DATA_W-1:0]  s_tdata,
  // output stream: [0] goal_valid, [12:1] goal_x, [23:13] goal_y,
  // [24] goal_wall_mode, [25] recalibrating, [26] fix_x_valid,
  // [38:27] fix_x_value, [39] fix_y_valid, [50:40] fix_y_value,
  // [53:51] phase_out, [55:54] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [wbor_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned POS_W   = wbor_pkg::POS_W;
  localparam int unsigned X_W     = wbor_pkg::X_W;
  localparam int unsigned Y_W     = wbor_pkg::Y_W;
  localparam int unsigned CNT_W   = wbor_pkg::CNT_W;
  localparam int unsigned DIFF_W  = POS_W + 1;

  typedef enum logic [wbor_pkg::PHASE_W-1:0] {
    PH_GO_START  = 3'd0,
    PH_WAIT_X    = 3'd1,
    PH_X_WALL    = 3'd2,
    PH_RETURN_X  = 3'd3,
    PH_Y_WALL    = 3'd4,
    PH_RETURN_Y  = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  // configuration registers
  logic [X_W-1:0] start_x;
  logic [Y_W-1:0] start_y;
  logic [1:0]     corner;
  logic           is_blue;

  // sequencer state
  phase_t                   phase, phase_next;
  logic signed [POS_W-1:0]  cand_x, cand_x_next;
  logic signed [POS_W-1:0]  cand_y, cand_y_next;
  logic [CNT_W-1:0]         cnt_x, cnt_x_next;
  logic [CNT_W-1:0]         cnt_y, cnt_y_next;
  logic                     recal, recal_next;

  // pipeline registers
  logic                     in_valid;
  logic signed [POS_W-1:0]  px, py;
  logic                     out_valid;
  wbor_pkg::result_t        out_res;
  wbor_pkg::result_t        res_next;

  logic advance;
  logic accept;

  // handshake: result register frees when taken, input register moves on
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(wbor_pkg::OUT_DATA_W - $bits(wbor_pkg::result_t)){1'b0}}, out_res};

  // corner decode
  logic own, bottom;
  assign own    = !corner[1];
  assign bottom = !corner[0];

  // distance to start point, window check before the small square
  logic signed [DIFF_W-1:0] ds_x, ds_y;
  logic [DIFF_W-1:0]        as_x, as_y;
  logic [11:0]              sq_sx, sq_sy;
  logic [12:0]              sum_s;
  logic                     at_start;

  assign ds_x  = $signed({2'b00, start_x}) - $signed({px[POS_W-1], px});
  assign ds_y  = $signed({3'b000, start_y}) - $signed({py[POS_W-1], py});
  assign as_x  = ds_x[DIFF_W-1] ? DIFF_W'(-ds_x) : DIFF_W'(ds_x);
  assign as_y  = ds_y[DIFF_W-1] ? DIFF_W'(-ds_y) : DIFF_W'(ds_y);
  assign sq_sx = {6'b0, as_x[5:0]} * {6'b0, as_x[5:0]};
  assign sq_sy = {6'b0, as_y[5:0]} * {6'b0, as_y[5:0]};
  assign sum_s = {1'b0, sq_sx} + {1'b0, sq_sy};
  assign at_start = (as_x < DIFF_W'(wbor_pkg::ARRIVE_RADIUS))
                 && (as_y < DIFF_W'(wbor_pkg::ARRIVE_RADIUS))
                 && (sum_s < 13'(wbor_pkg::ARRIVE_SQ));

  // distance to the stall candidate
  logic signed [DIFF_W-1:0] dc_x, dc_y;
  logic [DIFF_W-1:0]        ac_x, ac_y;
  logic [5:0]               sq_cx, sq_cy;
  logic [6:0]               sum_c;
  logic                     still;

  assign dc_x  = $signed({cand_x[POS_W-1], cand_x}) - $signed({px[POS_W-1], px});
  assign dc_y  = $signed({cand_y[POS_W-1], cand_y}) - $signed({py[POS_W-1], py});
  assign ac_x  = dc_x[DIFF_W-1] ? DIFF_W'(-dc_x) : DIFF_W'(dc_x);
  assign ac_y  = dc_y[DIFF_W-1] ? DIFF_W'(-dc_y) : DIFF_W'(dc_y);
  assign sq_cx = {3'b0, ac_x[2:0]} * {3'b0, ac_x[2:0]};
  assign sq_cy = {3'b0, ac_y[2:0]} * {3'b0, ac_y[2:0]};
  assign sum_c = {1'b0, sq_cx} + {1'b0, sq_cy};
  assign still = (ac_x < DIFF_W'(wbor_pkg::STILL_RADIUS))
              && (ac_y < DIFF_W'(wbor_pkg::STILL_RADIUS))
              && (sum_c < 7'(wbor_pkg::STILL_SQ));

  // wall thresholds
  logic past_x, past_y;
  assign past_x = own    ? (px < wbor_pkg::X_LOW_LIMIT) : (px > wbor_pkg::X_HIGH_LIMIT);
  assign past_y = bottom ? (py < wbor_pkg::Y_LOW_LIMIT) : (py > wbor_pkg::Y_HIGH_LIMIT);

  // saturating counter step, one per wall
  logic [CNT_W-1:0] inc_x, inc_y;
  assign inc_x = (cnt_x == '1) ? cnt_x : cnt_x + CNT_W'(1);
  assign inc_y = (cnt_y == '1) ? cnt_y : cnt_y + CNT_W'(1);

  // one tick of the sequencer
  always_comb begin
    phase_next  = phase;
    cand_x_next = cand_x;
    cand_y_next = cand_y;
    cnt_x_next  = cnt_x;
    cnt_y_next  = cnt_y;
    recal_next  = recal;
    res_next    = '0;

    // first tick issues the start goal, then falls into the wait
    if (phase_next == PH_GO_START) begin
      res_next.goal_valid = 1'b1;
      res_next.goal_x     = start_x;
      res_next.goal_y     = start_y;
      phase_next          = PH_WAIT_X;
    end

    // at the start point: head for the X wall, may chain into the approach
    if (phase_next == PH_WAIT_X && at_start) begin
      res_next.goal_valid     = 1'b1;
      res_next.goal_x         = own ? '0 : wbor_pkg::X_WALL_FAR;
      res_next.goal_y         = start_y;
      res_next.goal_wall_mode = 1'b1;
      recal_next              = 1'b1;
      phase_next              = PH_X_WALL;
    end

    unique case (phase_next)
      PH_X_WALL: begin
        if (still) begin
          cnt_x_next = inc_x;
        end else begin
          cnt_x_next  = '0;
          cand_x_next = px;
          cand_y_next = py;
        end
        if (cnt_x_next > CNT_W'(STALL_TICKS) && past_x) begin
          res_next.fix_x_valid = 1'b1;
          res_next.fix_x_value = (own ^ is_blue) ? wbor_pkg::FIX_X_NEAR
                                                 : wbor_pkg::FIX_X_FAR;
          res_next.goal_valid  = 1'b1;
          res_next.goal_x      = start_x;
          res_next.goal_y      = start_y;
          res_next.goal_wall_mode = 1'b0;
          recal_next           = 1'b0;
          phase_next           = PH_RETURN_X;
          cnt_x_next           = '0;
        end
      end
      PH_RETURN_X: begin
        if (at_start) begin
          res_next.goal_valid     = 1'b1;
          res_next.goal_x         = start_x;
          res_next.goal_y         = bottom ? '0 : wbor_pkg::Y_WALL_FAR;
          res_next.goal_wall_mode = 1'b1;
          phase_next              = PH_Y_WALL;
        end
      end
      PH_Y_WALL: begin
        if (still) begin
          cnt_y_next = inc_y;
        end else begin
          cnt_y_next  = '0;
          cand_x_next = px;
          cand_y_next = py;
        end
        if (cnt_y_next > CNT_W'(STALL_TICKS) && past_y) begin
          res_next.fix_y_valid = 1'b1;
          res_next.fix_y_value = bottom ? wbor_pkg::FIX_Y_NEAR : wbor_pkg::FIX_Y_FAR;
          recal_next           = 1'b0;
          res_next.goal_valid  = 1'b1;
          res_next.goal_x      = start_x;
          res_next.goal_y      = start_y;
          phase_next           = PH_RETURN_Y;
          cnt_y_next           = '0;
        end
      end
      PH_RETURN_Y: begin
        if (at_start) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
        // waiting at the start point, or done: hold
      end
    endcase

    res_next.recalibrating = recal_next;
    res_next.phase_out     = phase_next;
  end

  // control state, configuration and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= wbor_pkg::START_X_RST;
      start_y   <= wbor_pkg::START_Y_RST;
      corner    <= '0;
      is_blue   <= 1'b0;
      phase     <= PH_GO_START;
      cand_x    <= '0;
      cand_y    <= '0;
      cnt_x     <= '0;
      cnt_y     <= '0;
      recal     <= 1'b0;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (wbor_pkg::cfg_index_t'(cfg_index))
          wbor_pkg::CFG_START_X: start_x <= cfg_data[X_W-1:0];
          wbor_pkg::CFG_START_Y: start_y <= cfg_data[Y_W-1:0];
          wbor_pkg::CFG_CORNER:  corner  <= cfg_data[1:0];
          wbor_pkg::CFG_IS_BLUE: is_blue <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // sequencer state moves with each request
      if (advance) begin
        phase  <= phase_next;
        cand_x <= cand_x_next;
        cand_y <= cand_y_next;
        cnt_x  <= cnt_x_next;
        cnt_y  <= cnt_y_next;
        recal  <= recal_next;
      end

      // stage valid flags
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= s_tdata[POS_W-1:0];
      py <= s_tdata[2*POS_W-1:POS_W];
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  // recalibration flag is only up during the X-wall approach
  assert property (@(posedge clk) disable iff (rst) recal |-> (phase == PH_X_WALL))
    else $error("recalibration flag high outside the X-wall approach");

  // stall counters only run in their own approach phase
  assert property (@(posedge clk) disable iff (rst)
    (cnt_x != '0) |-> (phase == PH_X_WALL))
    else $error("X-wall counter running outside its phase");

  assert property (@(posedge clk) disable iff (rst)
    (cnt_y != '0) |-> (phase == PH_Y_WALL))
    else $error("Y-wall counter running outside its phase");

  // a correction always comes with the return goal
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.fix_x_valid || out_res.fix_y_valid))
      |-> (out_res.goal_valid && !out_res.goal_wall_mode))
    else $error("odometry correction without a return goal");

  // the phase advances only when a request moves through
  assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(phase))
    else $error("phase changed without a request");

endmodule

`default_nettype wire

>>> verif/tb_wall_bump_odometry_recalibration_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_bump_odometry_recalibration_core: homing sequencer testbench
// Walks the core once through its whole homing sequence: start goal, X wall
// stall and correction, return, Y wall stall and correction, return, done.
// Every response is compared field by field with a local model of the
// sequencer, while both stream sides stall at random.
// ----------------------------------------------------------------------------

module tb_wall_bump_odometry_recalibration_core;

  localparam int CYCLE_LIMIT = 200000;

  localparam int unsigned POS_W      = wbor_pkg::POS_W;
  localparam int unsigned X_W        = wbor_pkg::X_W;
  localparam int unsigned Y_W        = wbor_pkg::Y_W;
  localparam int unsigned PHASE_W    = wbor_pkg::PHASE_W;
  localparam int unsigned CFG_IDX_W  = wbor_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = wbor_pkg::CFG_DATA_W;
  localparam int unsigned IN_DATA_W  = wbor_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = wbor_pkg::OUT_DATA_W;

  typedef wbor_pkg::result_t result_t;

  // homing phases
  localparam logic [PHASE_W-1:0] PH_ISSUE_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEEK_START  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_X_WALL      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_X_RETURN    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_Y_WALL      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_Y_RETURN    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE        = 3'd6;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } odo_tick_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = wbor_pkg::CFG_START_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // model configuration and state
  logic [X_W-1:0]     cfg_start_x = wbor_pkg::START_X_RST;
  logic [Y_W-1:0]     cfg_start_y = wbor_pkg::START_Y_RST;
  logic [1:0]         cfg_corner = 2'd0;
  logic               cfg_blue = 1'b0;
  logic [PHASE_W-1:0] home_phase = PH_ISSUE_START;
  int                 cand_x = 0;
  int                 cand_y = 0;
  int                 x_still = 0;
  int                 y_still = 0;
  bit                 recal_level = 1'b0;

  odo_tick_t odometry_ticks[$];
  result_t   homing_outcomes[$];

  logic in_fire = 1'b0;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_cycles = 0;
  bit   calm;

  wall_bump_odometry_recalibration_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no random stalls while the long X wall hold streams through
  assign calm = (n_accepted >= 100) && (n_accepted < 280);

  function automatic int sq_dist(int ax, int ay, int bx, int by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  // stillness counter around the remembered candidate point
  function automatic int follow_stall(int cnt, int px, int py);
    if (sq_dist(cand_x, cand_y, px, py) < wbor_pkg::STILL_SQ) begin
      if (cnt < 255) cnt++;
    end else begin
      cnt = 0;
      cand_x = px;
      cand_y = py;
    end
    return cnt;
  endfunction

  // one control tick of the sequencer, updates the model state
  function automatic result_t homing_step(int px, int py);
    result_t r;
    bit      own;
    bit      bottom;
    bit      at_start;
    bit      past;
    r = '0;
    own = (cfg_corner < 2'd2);
    bottom = !cfg_corner[0];
    at_start = sq_dist(cfg_start_x, cfg_start_y, px, py) < wbor_pkg::ARRIVE_SQ;

    // first tick: head for the start point, may chain into the wall approach
    if (home_phase == PH_ISSUE_START) begin
      r.goal_valid = 1'b1;
      r.goal_x = cfg_start_x;
      r.goal_y = cfg_start_y;
      home_phase = PH_SEEK_START;
    end
    if (home_phase == PH_SEEK_START && at_start) begin
      r.goal_valid = 1'b1;
      r.goal_x = own ? 12'd0 : wbor_pkg::X_WALL_FAR;
      r.goal_y = cfg_start_y;
      r.goal_wall_mode = 1'b1;
      recal_level = 1'b1;
      home_phase = PH_X_WALL;
    end

    case (home_phase)
      PH_X_WALL: begin
        x_still = follow_stall(x_still, px, py);
        past = own ? (px < wbor_pkg::X_LOW_LIMIT) : (px > wbor_pkg::X_HIGH_LIMIT);
        if (x_still > wbor_pkg::STALL_TICKS && past) begin
          r.fix_x_valid = 1'b1;
          r.fix_x_value = (own ^ cfg_blue) ? wbor_pkg::FIX_X_NEAR : wbor_pkg::FIX_X_FAR;
          r.goal_valid = 1'b1;
          r.goal_x = cfg_start_x;
          r.goal_y = cfg_start_y;
          r.goal_wall_mode = 1'b0;
          recal_level = 1'b0;
          x_still = 0;
          home_phase = PH_X_RETURN;
        end
      end
      PH_X_RETURN: begin
        if (at_start) begin
          r.goal_valid = 1'b1;
          r.goal_x = cfg_start_x;
          r.goal_y = bottom ? 11'd0 : wbor_pkg::Y_WALL_FAR;
          r.goal_wall_mode = 1'b1;
          home_phase = PH_Y_WALL;
        end
      end
      PH_Y_WALL: begin
        y_still = follow_stall(y_still, px, py);
        past = bottom ? (py < wbor_pkg::Y_LOW_LIMIT) : (py > wbor_pkg::Y_HIGH_LIMIT);
        if (y_still > wbor_pkg::STALL_TICKS && past) begin
          r.fix_y_valid = 1'b1;
          r.fix_y_value = bottom ? wbor_pkg::FIX_Y_NEAR : wbor_pkg::FIX_Y_FAR;
          r.goal_valid = 1'b1;
          r.goal_x = cfg_start_x;
          r.goal_y = cfg_start_y;
          r.goal_wall_mode = 1'b0;
          recal_level = 1'b0;
          y_still = 0;
          home_phase = PH_Y_RETURN;
        end
      end
      PH_Y_RETURN: begin
        if (at_start) home_phase = PH_DONE;
      end
      default: ;
    endcase

    r.recalibrating = recal_level;
    r.phase_out = home_phase;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  task automatic push_tick(int x, int y);
    odo_tick_t t;
    t.x = x[POS_W-1:0];
    t.y = y[POS_W-1:0];
    odometry_ticks.push_back(t);
    n_queued++;
  endtask

  // random positions over the whole field range, kept clear of one point
  task automatic roam(int n, int ax, int ay);
    int x;
    int y;
    repeat (n) begin
      do begin
        x = int'($urandom_range(0, 8191)) - 4096;
        y = int'($urandom_range(0, 8191)) - 4096;
      end while (sq_dist(ax, ay, x, y) < 2500);
      push_tick(x, y);
    end
  endtask

  // small wobble around a point; s * [lo..3] across the wall, +-3 along it
  task automatic jitter_at(int cx, int cy, int n, bit across_x, int s, int lo);
    int r;
    int o;
    repeat (n) begin
      r = lo + int'($urandom_range(0, 3 - lo));
      o = int'($urandom_range(0, 6)) - 3;
      if (across_x) push_tick(cx + s * r, cy + o);
      else push_tick(cx + o, cy + s * r);
    end
  endtask

  task automatic wait_idle();
    while (n_checked != n_queued) @(negedge clk);
  endtask

  task automatic write_reg(wbor_pkg::cfg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      wbor_pkg::CFG_START_X: cfg_start_x = value[X_W-1:0];
      wbor_pkg::CFG_START_Y: cfg_start_y = value[Y_W-1:0];
      wbor_pkg::CFG_CORNER:  cfg_corner = value[1:0];
      wbor_pkg::CFG_IS_BLUE: cfg_blue = value[0];
      default: ;
    endcase
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    odo_tick_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (odometry_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
        nxt = odometry_ticks.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - 2 * POS_W){1'b0}}, nxt.y, nxt.x};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 24);
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin : watch_streams
    result_t got;
    result_t want;
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      homing_outcomes.push_back(homing_step(int'($signed(s_tdata[POS_W-1:0])),
                                            int'($signed(s_tdata[2*POS_W-1:POS_W]))));
      n_accepted++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (homing_outcomes.size() == 0) begin
        $error("result with no request waiting: %h", m_tdata);
        n_errors++;
      end else begin
        want = homing_outcomes.pop_front();
        check_field("goal_valid", want.goal_valid, got.goal_valid);
        check_field("goal_x", want.goal_x, got.goal_x);
        check_field("goal_y", want.goal_y, got.goal_y);
        check_field("goal_wall_mode", want.goal_wall_mode, got.goal_wall_mode);
        check_field("recalibrating", want.recalibrating, got.recalibrating);
        check_field("fix_x_valid", want.fix_x_valid, got.fix_x_valid);
        check_field("fix_x_value", want.fix_x_value, got.fix_x_value);
        check_field("fix_y_valid", want.fix_y_valid, got.fix_y_valid);
        check_field("fix_y_value", want.fix_y_value, got.fix_y_value);
        check_field("phase_out", want.phase_out, got.phase_out);
        n_checked++;
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run_homing
    int corner_sel;
    int team_sel;
    int s;
    int edge_pos;
    int hold_x;
    int hold_y;
    int final_x;
    int end_x;
    int end_y;

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // start under reset configuration: either straight into the X wall
    // approach on the first tick, or a wait on the arrival window edge
    if ($urandom_range(0, 1) == 1) begin
      push_tick(720, 1330);
    end else begin
      push_tick(-4096, 4095);
      push_tick(4095, -4096);
      push_tick(740, 1360);
      push_tick(660, 1360);
      push_tick(700, 1400);
      push_tick(724, 1392);
      push_tick(739, 1360);
    end
    // X wall approach: field extremes and an exact 5 mm move
    push_tick(0, 0);
    push_tick(-1, -1);
    push_tick(-4096, -4096);
    push_tick(4095, 4095);
    push_tick(150, 1000);
    push_tick(153, 1004);
    push_tick(149, 1000);
    wait_idle();

    // X wall under a random corner; start sits on the contact point so the
    // return phase must not be evaluated in the correction tick
    corner_sel = $urandom_range(0, 3);
    team_sel = $urandom_range(0, 1);
    s = (corner_sel < 2) ? -1 : 1;
    edge_pos = (corner_sel < 2) ? 150 : 2850;
    hold_x = edge_pos - 3 * s;
    final_x = edge_pos + s;
    hold_y = $urandom_range(300, 1700);
    write_reg(wbor_pkg::CFG_START_X, final_x);
    write_reg(wbor_pkg::CFG_START_Y, hold_y);
    write_reg(wbor_pkg::CFG_CORNER, corner_sel);
    write_reg(wbor_pkg::CFG_IS_BLUE, team_sel);
    roam(25, hold_x, hold_y);
    push_tick(hold_x, hold_y);
    // long hold short of the threshold saturates the counter
    jitter_at(hold_x, hold_y, 260, 1'b1, s, -3);
    push_tick(final_x, hold_y);
    wait_idle();

    // return to a start point in the low corner of the field
    corner_sel = $urandom_range(0, 3);
    write_reg(wbor_pkg::CFG_START_X, 0);
    write_reg(wbor_pkg::CFG_START_Y, 0);
    write_reg(wbor_pkg::CFG_CORNER, corner_sel);
    roam(20, 0, 0);
    push_tick(40, 0);
    push_tick(0, -40);
    push_tick(-24, 32);
    push_tick(-23, 32);

    // Y wall: hold short of it, step exactly 5 mm past it, hold to the limit
    s = corner_sel[0] ? 1 : -1;
    edge_pos = corner_sel[0] ? 1850 : 150;
    hold_x = $urandom_range(300, 2700);
    roam(20, 0, 0);
    push_tick(hold_x, edge_pos - 3 * s);
    jitter_at(hold_x, edge_pos - 3 * s, 40, 1'b0, s, -3);
    hold_y = edge_pos + 2 * s;
    push_tick(hold_x, hold_y);
    jitter_at(hold_x, hold_y, 100, 1'b0, s, -1);
    wait_idle();

    // new start takes effect on the correction tick
    write_reg(wbor_pkg::CFG_START_X, 3000);
    write_reg(wbor_pkg::CFG_START_Y, 2000);
    write_reg(wbor_pkg::CFG_CORNER, corner_sel ^ 2);
    write_reg(wbor_pkg::CFG_IS_BLUE, !team_sel);
    jitter_at(hold_x, hold_y, 1, 1'b0, s, -1);

    // final return, then done holds
    roam(20, 3000, 2000);
    push_tick(3040, 2000);
    push_tick(3000, 1960);
    push_tick(2975, 1975);
    roam(8, 3000, 2000);
    push_tick(3000, 2000);
    wait_idle();

    end_x = $urandom_range(0, 3000);
    end_y = $urandom_range(0, 2000);
    write_reg(wbor_pkg::CFG_START_X, end_x);
    write_reg(wbor_pkg::CFG_START_Y, end_y);
    write_reg(wbor_pkg::CFG_CORNER, $urandom_range(0, 3));
    write_reg(wbor_pkg::CFG_IS_BLUE, $urandom_range(0, 1));
    roam(8, end_x, end_y);
    push_tick(end_x, end_y);
    wait_idle();

    repeat (8) @(negedge clk);
    if (n_errors == 0 && homing_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
